// ----- sv/assert_macros.svh -----
// Assertion helpers for the RTL, included by cal_engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property checked at every rising clock edge outside reset.
`define CAL_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same-cycle implication.
`define CAL_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CAL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/cal_pkg.sv -----
package cal_pkg;

    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned S_DATA_W = 72;
    localparam int unsigned M_DATA_W = 8;
    localparam logic [5:0]  PLEN_MAX = 6'd32;

    localparam logic [1:0] CFG_PER_IP_LIMIT    = 2'd0;
    localparam logic [1:0] CFG_MAX_CONNECTIONS = 2'd1;
    localparam logic [1:0] CFG_FLAG_ONLY       = 2'd2;

    localparam logic [6:0] MAX_CONN_RESET = 7'd40;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_OPEN  = 2'd1,
        CMD_CLOSE = 2'd2,
        CMD_RSVD  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        STAT_ADMITTED      = 3'd0,
        STAT_FLAGGED       = 3'd1,
        STAT_REFUSED_LIMIT = 3'd2,
        STAT_REFUSED_FULL  = 3'd3,
        STAT_RULE_ADDED    = 3'd4,
        STAT_RULES_FULL    = 3'd5,
        STAT_CLOSED        = 3'd6
    } status_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FREE,
        ST_RULE,
        ST_COUNT,
        ST_DECIDE,
        ST_FIND,
        ST_CRULE,
        ST_CFREE,
        ST_DONE
    } state_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [31:0] address;
        logic [31:0] mask;
        logic [15:0] rule_limit;
        logic [15:0] conn_id;
    } item_t;

    typedef struct packed {
        logic [15:0] per_ip_limit;
        logic [6:0]  max_connections;
        logic        flag_only;
    } cfg_t;

endpackage

// ----- sv/connection_admission_limiter.sv -----
// Connection admission limiter.
// Input words arrive on s_*: tuser carries the command (add rule, open, close),
// tdata the address, prefix length, rule limit and connection id. Each word
// yields exactly one result word on m_*: tuser is the status, tdata the slot
// and the found flag. Registers are written through cfg_we/cfg_index/cfg_wdata
// while the block is idle; this binds the user, the block itself does not enforce it.
// Words are worked on one at a time by a sequencer that walks the rule and
// slot memories one entry per cycle. An add is done in the idle state; an
// open runs the free slot search, the rule search and, with no rule hit and a
// per-address limit set, the per-address count; a close runs the slot search,
// the rule search and the slot release. A two-word queue in front accepts new
// words while the sequencer is busy.
// After reset the slot table is cleared, one slot per cycle; no word is taken
// during that pass, configuration writes are.
// A stalled receiver holds the result in the output register; the sequencer
// then waits at the end of the next word and the input queue fills up.
module connection_admission_limiter #(
    parameter int RULES = 16,
    parameter int SLOTS = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // address[31:0], prefix_len[37:32], rule_limit[53:38], conn_id[69:54], zero fill
    input  logic [cal_pkg::S_DATA_W-1:0]    s_tdata,
    // cmd[1:0]
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // slot[5:0], found[6], zero fill
    output logic [cal_pkg::M_DATA_W-1:0]    m_tdata,
    // status[2:0]
    output logic [2:0]                      m_tuser,
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_index,
    input  logic [15:0]                     cfg_wdata
);
    import cal_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    logic  q_valid;
    item_t q_item;
    logic  pop;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_PER_IP_LIMIT:    cfg_next.per_ip_limit    = cfg_wdata;
                CFG_MAX_CONNECTIONS: cfg_next.max_connections = cfg_wdata[6:0];
                CFG_FLAG_ONLY:       cfg_next.flag_only       = cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.per_ip_limit    <= 16'd0;
            cfg_reg.max_connections <= MAX_CONN_RESET;
            cfg_reg.flag_only       <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    cal_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_item   (q_item)
    );

    cal_engine #(
        .RULES (RULES),
        .SLOTS (SLOTS)
    ) u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ----- sv/cal_front.sv -----
module cal_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // address[31:0], prefix_len[37:32], rule_limit[53:38], conn_id[69:54], zero fill
    input  logic [cal_pkg::S_DATA_W-1:0]    s_tdata,
    // cmd[1:0]
    input  logic [1:0]                      s_tuser,
    input  logic                            pop,
    output logic                            q_valid,
    output cal_pkg::item_t                  q_item
);
    import cal_pkg::*;

    item_t       q_mem [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push;
    logic [5:0]  plen;
    logic [5:0]  len;
    item_t       in_item;

    // Clamp the prefix length and turn it into a mask up front.
    always_comb begin
        plen = s_tdata[37:32];
        len  = (plen > PLEN_MAX) ? PLEN_MAX : plen;
        in_item.cmd        = cmd_t'(s_tuser);
        in_item.address    = s_tdata[31:0];
        in_item.mask       = 32'hFFFF_FFFF << (PLEN_MAX - len);
        in_item.rule_limit = s_tdata[53:38];
        in_item.conn_id    = s_tdata[69:54];
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = q_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ----- sv/cal_engine.sv -----
module cal_engine #(
    parameter int RULES = 16,
    parameter int SLOTS = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  cal_pkg::cfg_t                   cfg,
    input  logic                            q_valid,
    input  cal_pkg::item_t                  q_item,
    output logic                            pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // slot[5:0], found[6], zero fill
    output logic [cal_pkg::M_DATA_W-1:0]    m_tdata,
    // status[2:0]
    output logic [2:0]                      m_tuser
);
    import cal_pkg::*;
    `include "assert_macros.svh"

    localparam int MAXN = (SLOTS > RULES) ? SLOTS : RULES;
    localparam int CW   = $clog2(MAXN + 1);
    localparam int SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int RW   = (RULES > 1) ? $clog2(RULES) : 1;
    localparam int RUW  = $clog2(RULES + 1);
    localparam int UW   = (CW > 7) ? CW : 7;
    localparam int PW   = (CW > 16) ? CW + 1 : 17;
    localparam logic [UW-1:0]  SLOTS_U   = UW'(SLOTS);
    localparam logic [CW-1:0]  SLOTS_C   = CW'(SLOTS);
    localparam logic [CW-1:0]  LAST_SLOT = CW'(SLOTS - 1);
    localparam logic [RUW-1:0] RULES_U   = RUW'(RULES);

    // Memories
    logic [15:0] slot_id_mem   [SLOTS];
    logic [31:0] slot_addr_mem [SLOTS];
    logic [31:0] rule_pfx_mem  [RULES];
    logic [31:0] rule_mask_mem [RULES];
    logic [15:0] rule_max_mem  [RULES];
    logic [15:0] rule_act_mem  [RULES];
    logic [15:0] sid_q;
    logic [31:0] saddr_q, rp_q, rm_q;
    logic [15:0] rmax_q, ract_q;

    logic          slot_we;
    logic [SW-1:0] slot_wa;
    logic [15:0]   slot_wid;
    logic [31:0]   slot_wad;
    logic          rule_we;
    logic [RW-1:0] rule_wa;
    logic          act_we;
    logic [RW-1:0] act_wa;
    logic [15:0]   act_wd;

    state_t          state_reg, state_next;
    item_t           cur_reg, cur_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            rv_reg, rv_next;
    logic [CW-1:0]   ridx_reg, ridx_next;
    logic [SW-1:0]   free_reg, free_next;
    logic [SW-1:0]   hslot_reg, hslot_next;
    logic [RW-1:0]   rule_reg, rule_next;
    logic [15:0]     rmax_reg, rmax_next;
    logic [15:0]     ract_reg, ract_next;
    logic            rhit_reg, rhit_next;
    logic [31:0]     caddr_reg, caddr_next;
    logic [CW-1:0]   pcnt_reg, pcnt_next;
    logic [RUW-1:0]  rused_reg, rused_next;
    status_t         rstat_reg, rstat_next;
    logic [5:0]      rslot_reg, rslot_next;
    logic            rfound_reg, rfound_next;
    logic            m_valid_reg, m_valid_next;
    status_t         m_status_reg, m_status_next;
    logic [5:0]      m_slot_reg, m_slot_next;
    logic            m_found_reg, m_found_next;

    logic [UW-1:0]   mc_ext, usable;
    logic [CW-1:0]   scan_lim;
    logic            hit;
    logic            scanning;
    logic            rule_over, ip_over, over;
    logic [SW+5:0]   free_x, hslot_x;
    logic [SW-1:0]   ridx_s;
    logic [RW-1:0]   ridx_r;

    always_comb begin
        mc_ext   = UW'(cfg.max_connections);
        usable   = (mc_ext < SLOTS_U) ? mc_ext : SLOTS_U;
        free_x   = {6'd0, free_reg};
        hslot_x  = {6'd0, hslot_reg};
        ridx_s   = ridx_reg[SW-1:0];
        ridx_r   = ridx_reg[RW-1:0];
        rule_over = ({1'b0, ract_reg} + 17'd1) > {1'b0, rmax_reg};
        ip_over   = (cfg.per_ip_limit != 16'd0)
                 && ((PW'(pcnt_reg) + PW'(1)) > PW'(cfg.per_ip_limit));
        over      = rhit_reg ? rule_over : ip_over;
    end

    // Scan limit and hit test of the entry read in the previous cycle.
    always_comb begin
        scan_lim = SLOTS_C;
        hit      = 1'b0;
        scanning = 1'b0;
        case (state_reg)
            ST_FREE: begin
                scan_lim = usable[CW-1:0];
                hit      = (sid_q == 16'd0);
                scanning = 1'b1;
            end
            ST_RULE: begin
                scan_lim = CW'(rused_reg);
                hit      = ((cur_reg.address & rm_q) == (rp_q & rm_q));
                scanning = 1'b1;
            end
            ST_COUNT: begin
                scanning = 1'b1;
            end
            ST_FIND: begin
                hit      = (sid_q == cur_reg.conn_id);
                scanning = 1'b1;
            end
            ST_CRULE: begin
                scan_lim = CW'(rused_reg);
                hit      = ((caddr_reg & rm_q) == (rp_q & rm_q));
                scanning = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        cnt_next    = cnt_reg;
        rv_next     = rv_reg;
        ridx_next   = ridx_reg;
        free_next   = free_reg;
        hslot_next  = hslot_reg;
        rule_next   = rule_reg;
        rmax_next   = rmax_reg;
        ract_next   = ract_reg;
        rhit_next   = rhit_reg;
        caddr_next  = caddr_reg;
        pcnt_next   = pcnt_reg;
        rused_next  = rused_reg;
        rstat_next  = rstat_reg;
        rslot_next  = rslot_reg;
        rfound_next = rfound_reg;
        pop         = 1'b0;
        slot_we     = 1'b0;
        slot_wa     = cnt_reg[SW-1:0];
        slot_wid    = 16'd0;
        slot_wad    = 32'd0;
        rule_we     = 1'b0;
        rule_wa     = rused_reg[RW-1:0];
        act_we      = 1'b0;
        act_wa      = rused_reg[RW-1:0];
        act_wd      = 16'd0;
        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_slot_next   = m_slot_reg;
        m_found_next  = m_found_reg;

        // Shared scan step: test the entry in flight, else issue the next read.
        if (scanning) begin
            if (!(rv_reg && hit)) begin
                if (cnt_reg < scan_lim) begin
                    cnt_next  = cnt_reg + CW'(1);
                    rv_next   = 1'b1;
                    ridx_next = cnt_reg;
                end else begin
                    rv_next = 1'b0;
                end
            end else begin
                rv_next = 1'b0;
            end
        end

        case (state_reg)
            ST_CLEAR: begin
                slot_we = 1'b1;
                if (cnt_reg == LAST_SLOT) begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ST_IDLE: begin
                cnt_next = '0;
                rv_next  = 1'b0;
                if (q_valid) begin
                    pop         = 1'b1;
                    cur_next    = q_item;
                    rslot_next  = 6'd0;
                    rfound_next = 1'b0;
                    state_next  = ST_DONE;
                    case (q_item.cmd)
                        CMD_ADD: begin
                            if (rused_reg < RULES_U) begin
                                rule_we    = 1'b1;
                                act_we     = 1'b1;
                                rused_next = rused_reg + RUW'(1);
                                rstat_next = STAT_RULE_ADDED;
                            end else begin
                                rstat_next = STAT_RULES_FULL;
                            end
                        end
                        CMD_OPEN: begin
                            if (q_item.conn_id == 16'd0 || usable == '0) begin
                                rstat_next = STAT_REFUSED_FULL;
                            end else begin
                                state_next = ST_FREE;
                            end
                        end
                        CMD_CLOSE: begin
                            rstat_next = STAT_CLOSED;
                            if (q_item.conn_id != 16'd0) begin
                                state_next = ST_FIND;
                            end
                        end
                        default: begin
                            rstat_next = STAT_ADMITTED;
                        end
                    endcase
                end
            end
            ST_FREE: begin
                if (rv_reg && hit) begin
                    free_next  = ridx_s;
                    cnt_next   = '0;
                    state_next = ST_RULE;
                end else if (!rv_reg && cnt_reg >= scan_lim) begin
                    rstat_next = STAT_REFUSED_FULL;
                    state_next = ST_DONE;
                end
            end
            ST_RULE: begin
                if (rv_reg && hit) begin
                    rule_next  = ridx_r;
                    rmax_next  = rmax_q;
                    ract_next  = ract_q;
                    rhit_next  = 1'b1;
                    state_next = ST_DECIDE;
                end else if (!rv_reg && cnt_reg >= scan_lim) begin
                    rhit_next = 1'b0;
                    pcnt_next = '0;
                    cnt_next  = '0;
                    state_next = (cfg.per_ip_limit == 16'd0) ? ST_DECIDE : ST_COUNT;
                end
            end
            ST_COUNT: begin
                if (rv_reg && sid_q != 16'd0 && saddr_q == cur_reg.address) begin
                    pcnt_next = pcnt_reg + CW'(1);
                end
                if (!rv_reg && cnt_reg >= scan_lim) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                rfound_next = rhit_reg;
                if (rhit_reg && !rule_over) begin
                    act_we = 1'b1;
                    act_wa = rule_reg;
                    act_wd = ract_reg + 16'd1;
                end
                if (over && !cfg.flag_only) begin
                    rstat_next = STAT_REFUSED_LIMIT;
                end else begin
                    rstat_next = over ? STAT_FLAGGED : STAT_ADMITTED;
                    rslot_next = free_x[5:0];
                    slot_we    = 1'b1;
                    slot_wa    = free_reg;
                    slot_wid   = cur_reg.conn_id;
                    slot_wad   = cur_reg.address;
                end
                state_next = ST_DONE;
            end
            ST_FIND: begin
                if (rv_reg && hit) begin
                    hslot_next = ridx_s;
                    caddr_next = saddr_q;
                    cnt_next   = '0;
                    state_next = ST_CRULE;
                end else if (!rv_reg && cnt_reg >= scan_lim) begin
                    state_next = ST_DONE;
                end
            end
            ST_CRULE: begin
                if (rv_reg && hit) begin
                    if (ract_q != 16'd0) begin
                        act_we = 1'b1;
                        act_wa = ridx_r;
                        act_wd = ract_q - 16'd1;
                    end
                    state_next = ST_CFREE;
                end else if (!rv_reg && cnt_reg >= scan_lim) begin
                    state_next = ST_CFREE;
                end
            end
            ST_CFREE: begin
                slot_we     = 1'b1;
                slot_wa     = hslot_reg;
                rfound_next = 1'b1;
                rslot_next  = hslot_x[5:0];
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = rstat_reg;
                    m_slot_next   = rslot_reg;
                    m_found_next  = rfound_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            cnt_reg     <= '0;
            rv_reg      <= 1'b0;
            rused_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            rv_reg      <= rv_next;
            rused_reg   <= rused_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg      <= cur_next;
        ridx_reg     <= ridx_next;
        free_reg     <= free_next;
        hslot_reg    <= hslot_next;
        rule_reg     <= rule_next;
        rmax_reg     <= rmax_next;
        ract_reg     <= ract_next;
        rhit_reg     <= rhit_next;
        caddr_reg    <= caddr_next;
        pcnt_reg     <= pcnt_next;
        rstat_reg    <= rstat_next;
        rslot_reg    <= rslot_next;
        rfound_reg   <= rfound_next;
        m_status_reg <= m_status_next;
        m_slot_reg   <= m_slot_next;
        m_found_reg  <= m_found_next;
    end

    always_ff @(posedge aclk) begin
        if (slot_we) begin
            slot_id_mem[slot_wa]   <= slot_wid;
            slot_addr_mem[slot_wa] <= slot_wad;
        end
        sid_q   <= slot_id_mem[cnt_reg[SW-1:0]];
        saddr_q <= slot_addr_mem[cnt_reg[SW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (rule_we) begin
            rule_pfx_mem[rule_wa]  <= cur_next.address;
            rule_mask_mem[rule_wa] <= cur_next.mask;
            rule_max_mem[rule_wa]  <= cur_next.rule_limit;
        end
        if (act_we) begin
            rule_act_mem[act_wa] <= act_wd;
        end
        rp_q   <= rule_pfx_mem[cnt_reg[RW-1:0]];
        rm_q   <= rule_mask_mem[cnt_reg[RW-1:0]];
        rmax_q <= rule_max_mem[cnt_reg[RW-1:0]];
        ract_q <= rule_act_mem[cnt_reg[RW-1:0]];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_found_reg, m_slot_reg};
    assign m_tuser  = m_status_reg;

    `CAL_ASSERT_IMPL(a_no_pop_in_clear, aclk, aresetn, state_reg == ST_CLEAR, !pop, "word taken during clear")
    `CAL_ASSERT(a_rules_bound, aclk, aresetn, rused_reg <= RULES_U, "rule count beyond table")
    `CAL_ASSERT_IMPL(a_refused_no_slot, aclk, aresetn, m_valid_reg && (m_status_reg == STAT_REFUSED_LIMIT || m_status_reg == STAT_REFUSED_FULL), m_slot_reg == 6'd0, "refused open reports a slot")
    `CAL_ASSERT_NEXT(a_pop_leaves_idle, aclk, aresetn, pop, state_reg != ST_IDLE, "popped word not worked on")

endmodule

// ----- test/connection_admission_limiter_tb.sv -----
module connection_admission_limiter_tb;
    import cal_pkg::*;

    localparam int RULES = 16;
    localparam int SLOTS = 64;

    typedef struct {
        status_t    status;
        logic [5:0] slot;
        logic       found;
    } admission_t;

    // Tracks the rule and slot tables and predicts one result word per input word.
    class admission_scoreboard;
        logic [31:0] rule_prefix[RULES];
        logic [31:0] rule_mask[RULES];
        int          rule_max[RULES];
        int          rule_active[RULES];
        int          rules_used;
        logic [15:0] slot_id[SLOTS];
        logic [31:0] slot_addr[SLOTS];
        int          per_ip_limit;
        int          max_conn;
        bit          flag_only;
        admission_t  pending[$];
        int          checked;

        function new();
            rules_used = 0;
            per_ip_limit = 0;
            max_conn = MAX_CONN_RESET;
            flag_only = 0;
            checked = 0;
            foreach (slot_id[i]) begin
                slot_id[i] = '0;
                slot_addr[i] = '0;
            end
        endfunction

        function int match_rule(logic [31:0] addr);
            for (int r = 0; r < rules_used; r++)
                if ((addr & rule_mask[r]) == (rule_prefix[r] & rule_mask[r]))
                    return r;
            return -1;
        endfunction

        function void note_word(cmd_t cmd, logic [31:0] addr, logic [5:0] plen,
                                logic [15:0] rlim, logic [15:0] id);
            admission_t res;
            int usable, free_slot, r, cnt, len;
            bit over;
            res.status = STAT_ADMITTED;
            res.slot = '0;
            res.found = 0;
            case (cmd)
                CMD_ADD: begin
                    if (rules_used < RULES) begin
                        len = (plen > PLEN_MAX) ? 32 : plen;
                        rule_prefix[rules_used] = addr;
                        rule_mask[rules_used] = (len == 0) ? 32'h0 : ~(32'hFFFF_FFFF >> len);
                        rule_max[rules_used] = rlim;
                        rule_active[rules_used] = 0;
                        rules_used++;
                        res.status = STAT_RULE_ADDED;
                    end else begin
                        res.status = STAT_RULES_FULL;
                    end
                end
                CMD_OPEN: begin
                    usable = (max_conn < SLOTS) ? max_conn : SLOTS;
                    free_slot = usable;
                    for (int i = 0; i < usable; i++)
                        if (slot_id[i] == 0) begin
                            free_slot = i;
                            break;
                        end
                    if (id == 0 || free_slot >= usable) begin
                        res.status = STAT_REFUSED_FULL;
                    end else begin
                        over = 0;
                        r = match_rule(addr);
                        if (r >= 0) begin
                            res.found = 1;
                            if (rule_active[r] + 1 > rule_max[r]) over = 1;
                            else rule_active[r] = (rule_active[r] + 1) & 16'hFFFF;
                        end else begin
                            cnt = 0;
                            foreach (slot_id[i])
                                if (slot_id[i] != 0 && slot_addr[i] == addr) cnt++;
                            if (per_ip_limit != 0 && cnt + 1 > per_ip_limit) over = 1;
                        end
                        if (over && !flag_only) begin
                            res.status = STAT_REFUSED_LIMIT;
                        end else begin
                            res.status = over ? STAT_FLAGGED : STAT_ADMITTED;
                            slot_id[free_slot] = id;
                            slot_addr[free_slot] = addr;
                            res.slot = 6'(free_slot);
                        end
                    end
                end
                CMD_CLOSE: begin
                    res.status = STAT_CLOSED;
                    if (id != 0)
                        for (int i = 0; i < SLOTS; i++)
                            if (slot_id[i] == id) begin
                                r = match_rule(slot_addr[i]);
                                if (r >= 0 && rule_active[r] > 0) rule_active[r]--;
                                slot_id[i] = '0;
                                slot_addr[i] = '0;
                                res.found = 1;
                                res.slot = 6'(i);
                                break;
                            end
                end
                default: ;
            endcase
            pending.push_back(res);
        endfunction

        function bit check_result(logic [2:0] status, logic [5:0] slot, logic found,
                                  output string msg);
            admission_t e;
            if (pending.size() == 0) begin
                msg = $sformatf("unexpected word status=%0d slot=%0d found=%0d",
                                status, slot, found);
                return 0;
            end
            e = pending.pop_front();
            checked++;
            if (status !== e.status || slot !== e.slot || found !== e.found) begin
                msg = $sformatf("word %0d: got status=%0d slot=%0d found=%0d, want %0d/%0d/%0d",
                                checked, status, slot, found, e.status, e.slot, e.found);
                return 0;
            end
            return 1;
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_we = 0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;

    admission_scoreboard sb = new();
    int errors = 0;
    int send_idle = 0;
    int recv_idle = 0;
    int words_sent = 0;

    connection_admission_limiter #(.RULES(RULES), .SLOTS(SLOTS)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always #5 aclk = ~aclk;

    task automatic report(string msg);
        $display("tb: mismatch: %s", msg);
        errors++;
    endtask

    always @(negedge aclk)
        m_tready <= aresetn && ($urandom_range(99) >= recv_idle);

    always @(posedge aclk) begin
        string msg;
        if (aresetn && m_tvalid && m_tready)
            if (!sb.check_result(m_tuser, m_tdata[5:0], m_tdata[6], msg)) report(msg);
    end

    // Entered and left just after a falling edge; tvalid stays high between
    // back-to-back words.
    task automatic send_word(cmd_t cmd, logic [31:0] addr, logic [5:0] plen,
                             logic [15:0] rlim, logic [15:0] id);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid = 0;
            @(negedge aclk);
        end
        s_tvalid = 1;
        s_tuser = cmd;
        s_tdata = '0;
        s_tdata[69:0] = {id, rlim, plen, addr};
        do @(posedge aclk); while (!s_tready);
        sb.note_word(cmd, addr, plen, rlim, id);
        words_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid = 0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (SLOTS + RULES + 16) @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] value);
        cfg_we = 1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_we = 0;
        case (idx)
            CFG_PER_IP_LIMIT:    sb.per_ip_limit = value;
            CFG_MAX_CONNECTIONS: sb.max_conn = value[6:0];
            CFG_FLAG_ONLY:       sb.flag_only = value[0];
            default: ;
        endcase
    endtask

    function automatic logic [31:0] pick_addr();
        case ($urandom_range(9))
            0, 1:    return {8'd10, 24'($urandom_range(3))};
            2, 3:    return {24'hC0A801, 8'($urandom_range(3))};
            4, 5, 6: return 32'hC0A80200 + $urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] busy_id();
        int s;
        for (int t = 0; t < 8; t++) begin
            s = $urandom_range(SLOTS - 1);
            if (sb.slot_id[s] != 0) return sb.slot_id[s];
        end
        return 16'($urandom_range(1, 65535));
    endfunction

    task automatic random_word();
        int pick;
        logic [15:0] id;
        pick = $urandom_range(99);
        if (pick < 3 && sb.rules_used < RULES - 1) begin
            send_word(CMD_ADD, pick_addr() & 32'hFFFF_FF00, 6'($urandom_range(1, 63)),
                      ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(3)), '0);
        end else if (pick < 50) begin
            id = ($urandom_range(9) == 0) ? 16'($urandom_range(1, 8))
                                          : 16'($urandom_range(1, 65535));
            send_word(CMD_OPEN, pick_addr(), 6'($urandom), 16'($urandom), id);
        end else if (pick < 92) begin
            id = ($urandom_range(4) != 0) ? busy_id() : 16'($urandom);
            send_word(CMD_CLOSE, $urandom, 6'($urandom), 16'($urandom), id);
        end else if (pick < 96) begin
            send_word(cmd_t'($urandom_range(1, 3)), $urandom, 6'($urandom), 16'($urandom),
                      16'($urandom));
        end else begin
            send_word(CMD_OPEN, pick_addr(), 6'($urandom), 16'($urandom), '0);
        end
    endtask

    initial begin
        #40_000_000;
        $display("tb: timeout");
        $display("tb: failure");
        $finish;
    end

    initial begin
        repeat (12) @(negedge aclk);
        aresetn = 1;
        send_idle = 19;
        recv_idle = 69;

        // Directed words under the reset settings.
        send_word(CMD_ADD, 32'h0A00_0000, 6'd8, 16'd1, '0);
        send_word(CMD_ADD, 32'hC0A8_0100, 6'd24, 16'd0, '0);
        send_word(CMD_ADD, 32'hFFFF_FFFF, 6'd63, 16'hFFFF, '0);
        send_word(CMD_OPEN, 32'h0A01_0203, '0, '0, 16'd1);
        send_word(CMD_OPEN, 32'h0A09_0909, '0, '0, 16'd2);
        send_word(CMD_OPEN, 32'hC0A8_0105, '0, '0, 16'd3);
        send_word(CMD_OPEN, 32'hFFFF_FFFF, 6'h3F, 16'hFFFF, 16'hFFFF);
        send_word(CMD_OPEN, 32'h0000_0000, '0, '0, 16'd0);
        send_word(CMD_OPEN, 32'hC0A8_0201, '0, '0, 16'd7);
        send_word(CMD_OPEN, 32'hC0A8_0201, '0, '0, 16'd7);
        send_word(CMD_CLOSE, '0, '0, '0, 16'd7);
        send_word(CMD_CLOSE, '0, '0, '0, 16'd1);
        send_word(CMD_CLOSE, '0, '0, '0, 16'd1);
        send_word(CMD_CLOSE, '0, '0, '0, 16'd0);
        send_word(CMD_OPEN, 32'h0A01_0203, '0, '0, 16'd9);
        send_word(CMD_RSVD, 32'hFFFF_FFFF, 6'h3F, 16'hFFFF, 16'hFFFF);
        send_word(CMD_CLOSE, '0, '0, '0, 16'hFFFF);

        for (int ph = 0; ph < 6; ph++) begin
            wait_idle();
            if (ph == 2) begin send_idle = 69; recv_idle = 19; end
            if (ph == 4) begin send_idle = 0; recv_idle = 0; end
            case (ph)
                0: begin write_reg(CFG_PER_IP_LIMIT, 16'd1);
                         write_reg(CFG_MAX_CONNECTIONS, 16'd64);
                         write_reg(CFG_FLAG_ONLY, 16'd0); end
                1: begin write_reg(CFG_PER_IP_LIMIT, 16'd2);
                         write_reg(CFG_MAX_CONNECTIONS, 16'd1);
                         write_reg(CFG_FLAG_ONLY, 16'd1); end
                2: begin write_reg(CFG_PER_IP_LIMIT, 16'hFFFF);
                         write_reg(CFG_MAX_CONNECTIONS, 16'd40);
                         write_reg(CFG_FLAG_ONLY, 16'd0); end
                3: begin write_reg(CFG_PER_IP_LIMIT, 16'd0);
                         write_reg(CFG_MAX_CONNECTIONS, 16'd64);
                         write_reg(CFG_FLAG_ONLY, 16'd1); end
                4: begin write_reg(CFG_PER_IP_LIMIT, 16'd3);
                         write_reg(CFG_MAX_CONNECTIONS, 16'd8);
                         write_reg(CFG_FLAG_ONLY, 16'd0); end
                default: begin
                    write_reg(CFG_PER_IP_LIMIT, 16'd1);
                    write_reg(CFG_MAX_CONNECTIONS, 16'd64);
                    write_reg(CFG_FLAG_ONLY, 16'd1);
                    // Fill the rule table; a zero-length prefix catches everything
                    // left, and the next add finds the table full.
                    while (sb.rules_used < RULES - 1)
                        send_word(CMD_ADD, $urandom, 6'($urandom_range(16, 32)), 16'd2, '0);
                    send_word(CMD_ADD, '0, 6'd0, 16'd4, '0);
                    send_word(CMD_ADD, $urandom, 6'($urandom), 16'($urandom), 16'($urandom));
                end
            endcase
            for (int n = 0; n < 300; n++) begin
                if (ph == 1 && n == 150) wait_idle();
                random_word();
            end
        end

        wait_idle();
        $display("tb: %0d words sent, %0d results checked over six register settings",
                 words_sent, sb.checked);
        $display("tb: %0d rules loaded, %0d mismatches", sb.rules_used, errors);
        if (errors == 0 && sb.pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+sv
sv/cal_pkg.sv
sv/cal_front.sv
sv/cal_engine.sv
sv/connection_admission_limiter.sv
test/connection_admission_limiter_tb.sv
